[sv/pic_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, widths and constants of the 1-D particle push pipeline.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int GRID_NODES = 2048;
  localparam int IDX_W      = $clog2(GRID_NODES);

  localparam int POS_W      = 48;
  localparam int VEL_W      = 48;
  localparam int FLD_W      = 32;
  localparam int TS_W       = 32;
  localparam int FIDX_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP     = 2'd0,
    CFG_DOMAIN_LENGTH = 2'd1,
    CFG_HALF_KICK     = 2'd2
  } cfg_reg_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PUSH = 1'b1;

  localparam logic [TS_W-1:0]  TS_RESET = 32'd4294967;
  localparam logic [POS_W-1:0] DL_RESET = 48'd13100646400;
  localparam logic             HK_RESET = 1'b1;

  localparam logic signed [VEL_W-1:0] VMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VEL_W-1:0] VMIN = 48'sh8000_0000_0000;
  localparam logic [POS_W-1:0]        PMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic                    mode;
    logic [FIDX_W-1:0]       field_index;
    logic signed [FLD_W-1:0] field_value;
    logic [POS_W-1:0]        position;
    logic signed [VEL_W-1:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]        new_position;
    logic signed [VEL_W-1:0] new_velocity;
    logic                    wrapped;
  } out_item_t;

  // particle with its gathered field
  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [VEL_W-1:0] velocity;
    logic signed [FLD_W-1:0] field;
  } gather_t;

  // particle after the velocity kick
  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [VEL_W-1:0] velocity;
  } kick_t;

endpackage

[sv/pic_gather.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_gather
// Field table and linear interpolation of the field at the particle position.
// ----------------------------------------------------------------------------
module pic_gather import pic_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     ld_en,
  input  logic     push_en,
  input  in_item_t item,
  output logic     g_valid,
  output gather_t  g
);

  logic signed [FLD_W-1:0] mem [GRID_NODES];

  logic [IDX_W-1:0] waddr;
  logic             ld_ok;
  logic [IDX_W-1:0] j0;
  logic [IDX_W-1:0] j1;

  // stage 1: table read
  logic                    v1_r;
  logic signed [FLD_W-1:0] e0_r, e1_r;
  logic [POS_W-1:0]        pos1_r;
  logic signed [VEL_W-1:0] vel1_r;
  logic                    inr1_r;

  // stage 2: interpolation
  logic                    v2_r;
  gather_t                 g2_r;
  gather_t                 g2_nxt;

  logic signed [32:0]      diff;
  logic signed [50:0]      base;
  logic signed [50:0]      prod;
  logic signed [50:0]      acc;

  assign waddr = IDX_W'(item.field_index);
  assign ld_ok = (32'(item.field_index) < 32'(GRID_NODES));
  assign j0    = item.position[16 +: IDX_W];
  assign j1    = j0 + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (ld_en && ld_ok) begin
      mem[waddr] <= item.field_value;
    end
    e0_r   <= mem[j0];
    e1_r   <= mem[j1];
    pos1_r <= item.position;
    vel1_r <= item.velocity;
    // the field is zero from the last node on
    inr1_r <= (32'(item.position[POS_W-1:16]) < 32'(GRID_NODES - 1));
  end

  always_comb begin
    diff   = 33'(e1_r) - 33'(e0_r);
    base   = {{3{e0_r[FLD_W-1]}}, e0_r, 16'b0};
    prod   = 51'(diff) * 51'(signed'({1'b0, pos1_r[15:0]}));
    acc    = base + prod;
    g2_nxt.position = pos1_r;
    g2_nxt.velocity = vel1_r;
    g2_nxt.field    = inr1_r ? acc[47:16] : '0;
  end

  always_ff @(posedge clk) begin
    g2_r <= g2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= push_en;
      v2_r <= v1_r;
    end
  end

  assign g_valid = v2_r;
  assign g       = g2_r;

endmodule

[sv/pic_kick.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_kick
// Velocity kick by field times time step, full or half, with saturation.
// ----------------------------------------------------------------------------
module pic_kick import pic_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            g_valid,
  input  gather_t         g,
  input  logic [TS_W-1:0] time_step,
  input  logic            half_kick,
  output logic            k_valid,
  output kick_t           k
);

  // stage 3: field times time step
  logic                    v3_r;
  logic signed [64:0]      kprod_r;
  logic signed [64:0]      kprod_nxt;
  logic [POS_W-1:0]        pos3_r;
  logic signed [VEL_W-1:0] vel3_r;

  // stage 4: kicked velocity
  logic                    v4_r;
  kick_t                   k4_r;
  kick_t                   k4_nxt;

  logic signed [32:0]      kick;
  logic signed [49:0]      vsum;

  assign kprod_nxt = 65'(g.field) * 65'(signed'({1'b0, time_step}));

  always_ff @(posedge clk) begin
    kprod_r <= kprod_nxt;
    pos3_r  <= g.position;
    vel3_r  <= g.velocity;
  end

  always_comb begin
    kick = half_kick ? 33'(kprod_r >>> 33) : 33'(kprod_r >>> 32);
    vsum = 50'(vel3_r) + 50'(kick);
    k4_nxt.position = pos3_r;
    if (vsum > 50'(VMAX)) begin
      k4_nxt.velocity = VMAX;
    end else if (vsum < 50'(VMIN)) begin
      k4_nxt.velocity = VMIN;
    end else begin
      k4_nxt.velocity = vsum[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    k4_r <= k4_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= g_valid;
      v4_r <= v3_r;
    end
  end

  assign k_valid = v4_r;
  assign k       = k4_r;

endmodule

[sv/pic_drift.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_drift
// Position advance by velocity times time step, boundary wrap and clamp.
// ----------------------------------------------------------------------------
module pic_drift import pic_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             k_valid,
  input  kick_t            k,
  input  logic [TS_W-1:0]  time_step,
  input  logic [POS_W-1:0] domain_length,
  output logic             out_valid,
  output out_item_t        out_item
);

  // stage 5: two 48x16 partial products
  logic                    v5_r;
  logic signed [64:0]      hi_r, lo_r;
  logic signed [64:0]      hi_nxt, lo_nxt;
  logic [POS_W-1:0]        pos5_r;
  logic signed [VEL_W-1:0] vel5_r;

  // stage 6: combined product
  logic                    v6_r;
  logic signed [65:0]      sum_r;
  logic signed [65:0]      sum_nxt;
  logic [POS_W-1:0]        pos6_r;
  logic signed [VEL_W-1:0] vel6_r;

  // stage 7: raw new position
  logic                    v7_r;
  logic signed [50:0]      p_r;
  logic signed [50:0]      p_nxt;
  logic signed [VEL_W-1:0] vel7_r;

  // stage 8: wrap and clamp
  logic                    v8_r;
  out_item_t               o_r;
  out_item_t               o_nxt;

  logic signed [50:0]      dl;
  logic signed [50:0]      p2;
  logic signed [VEL_W-1:0] vneg;

  assign hi_nxt  = 65'(k.velocity) * 65'(signed'({1'b0, time_step[31:16]}));
  assign lo_nxt  = 65'(k.velocity) * 65'(signed'({1'b0, time_step[15:0]}));
  assign sum_nxt = 66'(hi_r) + 66'(lo_r >>> 16);
  assign p_nxt   = signed'({3'b0, pos6_r}) + 51'(sum_r >>> 16);

  always_comb begin
    dl    = signed'({3'b0, domain_length});
    vneg  = (vel7_r == VMIN) ? VMAX : -vel7_r;
    p2    = p_r;
    o_nxt.new_velocity = vel7_r;
    o_nxt.wrapped      = 1'b0;
    if (p_r >= dl) begin
      p2 = p_r - dl;
      o_nxt.new_velocity = vneg;
      o_nxt.wrapped      = 1'b1;
    end else if (p_r < 0) begin
      p2 = p_r + dl;
      o_nxt.new_velocity = vneg;
      o_nxt.wrapped      = 1'b1;
    end
    // a single wrap may still leave the range when far out
    if (p2 < 0) begin
      o_nxt.new_position = '0;
    end else if (p2 > signed'({3'b0, PMAX})) begin
      o_nxt.new_position = PMAX;
    end else begin
      o_nxt.new_position = p2[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    pos5_r <= k.position;
    vel5_r <= k.velocity;
    sum_r  <= sum_nxt;
    pos6_r <= pos5_r;
    vel6_r <= vel5_r;
    p_r    <= p_nxt;
    vel7_r <= vel6_r;
    o_r    <= o_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v5_r <= k_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  assign out_valid = v8_r;
  assign out_item  = o_r;

endmodule

[sv/pic_particle_push.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_particle_push
// Fixed-point 1-D leapfrog particle push with a loadable field table.
// ----------------------------------------------------------------------------
// The block takes one item every clock cycle: busy is always low. A load item
// writes the field table at the accepting edge and gives no result. A push
// item runs through an eight-stage pipeline (table read, interpolation, kick
// multiply, saturating kick, two 48x16 drift multiplies, product combine,
// position add, wrap and clamp). Its result shows on out_item with out_valid
// high for one cycle, once it has passed the last stage. The receiver
// cannot stall the pipeline, so results must be taken as they come. A push
// reading a table entry that was never loaded returns an undefined result.
// The user must write configuration only while no push is in flight; the
// block itself does not enforce this.
module pic_particle_push import pic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TS_W-1:0]  time_step_r;
  logic [POS_W-1:0] domain_length_r;
  logic             half_kick_r;

  logic    ld_en, push_en;
  logic    g_valid, k_valid;
  gather_t g;
  kick_t   k;

  assign busy    = 1'b0;
  assign ld_en   = start && !busy && (in_item.mode == MODE_LOAD);
  assign push_en = start && !busy && (in_item.mode == MODE_PUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r     <= TS_RESET;
      domain_length_r <= DL_RESET;
      half_kick_r     <= HK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_STEP:     time_step_r     <= cfg_data[TS_W-1:0];
        CFG_DOMAIN_LENGTH: domain_length_r <= cfg_data[POS_W-1:0];
        CFG_HALF_KICK:     half_kick_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pic_gather u_gather (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_en   (ld_en),
    .push_en (push_en),
    .item    (in_item),
    .g_valid (g_valid),
    .g       (g)
  );

  pic_kick u_kick (
    .clk       (clk),
    .rst_n     (rst_n),
    .g_valid   (g_valid),
    .g         (g),
    .time_step (time_step_r),
    .half_kick (half_kick_r),
    .k_valid   (k_valid),
    .k         (k)
  );

  pic_drift u_drift (
    .clk           (clk),
    .rst_n         (rst_n),
    .k_valid       (k_valid),
    .k             (k),
    .time_step     (time_step_r),
    .domain_length (domain_length_r),
    .out_valid     (out_valid),
    .out_item      (out_item)
  );

endmodule

[dv/push_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// push_checker
// Watches the item, result and register ports of the particle push block,
// keeps its own field table and registers, predicts every pushed particle
// and compares results in arrival order.
// ----------------------------------------------------------------------------
module push_checker import pic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    particles_in_flight,
  output int                    mismatch_count
);

  typedef logic signed [127:0] wide_t;

  logic signed [FLD_W-1:0] field_mem [GRID_NODES];
  logic [TS_W-1:0]         time_step;
  logic [POS_W-1:0]        domain_length;
  logic                    half_kick;
  out_item_t               pending_particles [$];
  out_item_t               oldest;

  function automatic wide_t clamp_velocity(wide_t v);
    wide_t vmax = VMAX;
    wide_t vmin = VMIN;
    if (v > vmax) return vmax;
    if (v < vmin) return vmin;
    return v;
  endfunction

  // gather, kick, drift and wrap of one particle
  function automatic out_item_t advance_particle(in_item_t it);
    logic [31:0] cell_no;
    wide_t       frac, e0, e1, fld, dt, v, p, dl, pmax;
    out_item_t   res;
    cell_no = it.position[POS_W-1:16];
    frac = it.position[15:0];
    dt   = time_step;
    dl   = domain_length;
    pmax = PMAX;
    fld  = '0;
    // no field past the last full cell
    if (cell_no < GRID_NODES - 1) begin
      e0  = field_mem[cell_no];
      e1  = field_mem[cell_no + 1];
      fld = ((wide_t'(65536) - frac) * e0 + frac * e1) >>> 16;
    end
    v = $signed(it.velocity);
    v = clamp_velocity(v + ((fld * dt) >>> (half_kick ? 33 : 32)));
    p = it.position;
    p = p + ((v * dt) >>> 32);
    res.wrapped = 1'b0;
    if (p >= dl) begin
      p = p - dl;
      v = clamp_velocity(-v);
      res.wrapped = 1'b1;
    end else if (p < 0) begin
      p = p + dl;
      v = clamp_velocity(-v);
      res.wrapped = 1'b1;
    end
    if (p < 0) p = 0;
    if (p > pmax) p = pmax;
    res.new_position = p[POS_W-1:0];
    res.new_velocity = v[VEL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      time_step     = TS_RESET;
      domain_length = DL_RESET;
      half_kick     = HK_RESET;
      pending_particles.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_STEP:     time_step = cfg_data[TS_W-1:0];
          CFG_DOMAIN_LENGTH: domain_length = cfg_data[POS_W-1:0];
          CFG_HALF_KICK:     half_kick = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.mode == MODE_PUSH) begin
          pending_particles.push_back(advance_particle(in_item));
        end else begin
          field_mem[in_item.field_index] = in_item.field_value;
        end
      end
      if (out_valid) begin
        if (pending_particles.size() == 0) begin
          $error("result with no particle in flight: new_position %h",
                 out_item.new_position);
          mismatch_count++;
        end else begin
          oldest = pending_particles.pop_front();
          if (out_item.new_position !== oldest.new_position) begin
            $error("new_position: expected %h, got %h",
                   oldest.new_position, out_item.new_position);
            mismatch_count++;
          end
          if (out_item.new_velocity !== oldest.new_velocity) begin
            $error("new_velocity: expected %h, got %h",
                   oldest.new_velocity, out_item.new_velocity);
            mismatch_count++;
          end
          if (out_item.wrapped !== oldest.wrapped) begin
            $error("wrapped: expected %b, got %b", oldest.wrapped, out_item.wrapped);
            mismatch_count++;
          end
        end
      end
    end
    particles_in_flight = pending_particles.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives field loads and particle pushes into pic_particle_push under several
// register settings and sender idling patterns; push_checker predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench import pic_pkg::*; ();

  localparam int CLK_HALF      = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 250;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIME_STEP;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          particles_in_flight;
  int          mismatch_count;
  int          stall_cycles;
  int          sender_idle_pct;
  bit          loaded [GRID_NODES];
  int          good_cells [$];
  logic [47:0] cur_domain;

  always #CLK_HALF clk = ~clk;

  pic_particle_push i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  push_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_item             (in_item),
    .out_valid           (out_valid),
    .out_item            (out_item),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .particles_in_flight (particles_in_flight),
    .mismatch_count      (mismatch_count)
  );

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // a cell whose two nodes both hold loaded field values
  function automatic int good_cell();
    return good_cells[$urandom_range(good_cells.size() - 1)];
  endfunction

  function automatic in_item_t load_item(int idx, logic signed [31:0] val);
    in_item_t it;
    it.mode        = MODE_LOAD;
    it.field_index = FIDX_W'(idx);
    it.field_value = val;
    it.position    = rand48();
    it.velocity    = rand48();
    loaded[idx]    = 1'b1;
    if (idx > 0 && loaded[idx-1]) good_cells.push_back(idx - 1);
    if (idx < GRID_NODES - 1 && loaded[idx+1]) good_cells.push_back(idx);
    return it;
  endfunction

  function automatic in_item_t push_item(logic [47:0] pos, logic [47:0] vel);
    in_item_t it;
    // never gather from a node that was not loaded
    if (pos[47:16] < GRID_NODES - 1 && !(loaded[pos[26:16]] && loaded[pos[26:16] + 1]))
      pos = {16'd0, 16'(good_cell()), pos[15:0]};
    it.mode        = MODE_PUSH;
    it.field_index = FIDX_W'($urandom_range(GRID_NODES - 1));
    it.field_value = $urandom;
    it.position    = pos;
    it.velocity    = vel;
    return it;
  endfunction

  function automatic logic [47:0] rand_velocity();
    logic [47:0] r;
    r = rand48();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return VMAX;
          1: return VMIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4: return {{23{r[24]}}, r[24:0]};
      5, 6:       return {{7{r[40]}}, r[40:0]};
      default:    return r;
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic [47:0]       pos;
    logic [9:0]        off;
    logic signed [31:0] val;
    int                idx;
    if ($urandom_range(3) == 0) begin
      idx = $urandom_range(1) ? $urandom_range(63) : $urandom_range(GRID_NODES - 1);
      case ($urandom_range(7))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        default: val = $urandom;
      endcase
      return load_item(idx, val);
    end
    off = 10'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: pos = {16'd0, 16'(good_cell()), 16'($urandom)};
      5:             pos = cur_domain - off;
      6:             pos = cur_domain + off;
      7:             pos = off;
      8:             pos = rand48();
      default:       pos = {16'd0, 16'($urandom_range(GRID_NODES)), 16'($urandom)};
    endcase
    return push_item(pos, rand_velocity());
  endfunction

  task automatic send(in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold the sender until every pushed particle has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (particles_in_flight != 0);
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] ts, logic [47:0] dl, logic hk);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIME_STEP;
    cfg_data  <= 48'(ts);
    @(posedge clk);
    cfg_index <= CFG_DOMAIN_LENGTH;
    cfg_data  <= dl;
    @(posedge clk);
    cfg_index <= CFG_HALF_KICK;
    cfg_data  <= 48'(hk);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_domain = dl;
  endtask

  initial begin
    int k;
    int phase;
    cur_domain      = DL_RESET;
    sender_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes at both ends of the table
    send(load_item(0, 32'sh7FFF_FFFF));
    send(load_item(1, 32'sh8000_0000));
    send(load_item(2, 32'sh0000_0000));
    send(load_item(3, 32'shFFFF_FFFF));
    send(load_item(4, 32'sh0001_8000));
    send(load_item(GRID_NODES - 2, 32'sh8000_0000));
    send(load_item(GRID_NODES - 1, 32'sh7FFF_FFFF));

    send(push_item(48'h0, 48'h0));
    // kick from VMAX against a negative field, then a wrap past the domain end
    send(push_item(48'h0000_0000_FFFF, VMAX));
    // saturating kick downward, wrap below zero and clamp at zero
    send(push_item(48'h0000_0001_0000, VMIN));
    send(push_item(48'h0000_0002_8000, 48'hFFFF_FFFF_FFFF));
    send(push_item(48'h0000_0003_0001, 48'h0000_0000_0001));
    send(push_item(48'h0, 48'hFFFF_FFFF_FFFF));
    send(push_item(DL_RESET - 48'd1, 48'h0000_0010_0000));
    send(push_item({16'd0, 16'(GRID_NODES - 2), 16'h8000}, VMAX));
    // last node: no field beyond it
    send(push_item({16'd0, 16'(GRID_NODES - 1), 16'h1234}, 48'h0000_0001_0000));
    send(push_item(PMAX, 48'h0));
    send(push_item(PMAX, VMAX));
    send(push_item(PMAX, VMIN));

    for (k = 0; k < PHASES * PHASE_ITEMS; k++) begin
      phase = k / PHASE_ITEMS;
      if (k % PHASE_ITEMS == 0) begin
        case (phase)
          1:       configure(32'hFFFF_FFFF, PMAX, 1'b0);
          2:       configure(32'h0, 48'd1, 1'b1);
          3:       configure($urandom, 48'd2048 << 16, 1'($urandom));
          4:       configure($urandom_range(1 << 24), rand48() | 48'd1, 1'($urandom));
          5:       configure($urandom, {16'd0, $urandom} | 48'd1, 1'b0);
          default: ;
        endcase
      end
      sender_idle_pct = (k < 500) ? 13 : (k < 1000) ? 83 : 0;
      if (k == 100 || $urandom_range(199) == 0) drain();
      send(random_item());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && particles_in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
